// ----- hw/rtl/cbcc_pkg.sv -----
// cbcc_pkg: shared constants, types and helpers for the circle/box collision classifier.
// Depends on nothing; imported by circle_box_collision_classify_unit.
package cbcc_pkg;

   // Coordinate format: signed fixed point, CoordBits wide with FracBits fraction bits.
   localparam int CoordBits = 32;
   localparam int FracBits  = 8;

   // Port and register widths fixed by the interface.
   localparam int FieldW   = 32;
   localparam int RadiusW  = 31;
   localparam int CsrW     = 64;
   localparam int CsrIdxW  = 3;
   localparam int BandW    = 31;

   // Datapath widths.
   localparam int DiffW  = CoordBits + 1;      // difference of two coordinates
   localparam int ProdW  = 2 * DiffW;          // product of two differences
   localparam int SumW   = ProdW + 1;          // sum of two products
   localparam int MagW   = ProdW;              // magnitude of a sum of two products
   localparam int RadW   = CoordBits - 1;      // radius bits that count
   localparam int R2W    = 2 * RadW;
   localparam int NumCh  = 3;                  // chunks per wide operand
   localparam int ChunkW = (MagW + NumCh - 1) / NumCh;
   localparam int PadW   = NumCh * ChunkW;
   localparam int PpW    = 2 * ChunkW;
   localparam int RowW   = PpW + (NumCh - 1) * ChunkW + 2;
   localparam int FullW  = 2 * PadW + 2;
   localparam int BandShW = BandW + FracBits;

   localparam int NumEdges = 4;

   // Register indexes.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_CORNER_A   = 3'd0,
      CSR_CORNER_B   = 3'd1,
      CSR_CORNER_C   = 3'd2,
      CSR_CORNER_D   = 3'd3,
      CSR_BOX_CENTER = 3'd4,
      CSR_AXIS       = 3'd5,
      CSR_BAND       = 3'd6
   } csr_idx_type;

   // Result class codes.
   typedef enum logic [1:0] {
      HIT_NONE   = 2'd0,
      HIT_CENTER = 2'd1,
      HIT_SIDE   = 2'd2
   } hit_class_type;

   localparam logic [1:0] TurnPos  = 2'b01;
   localparam logic [1:0] TurnNeg  = 2'b11;
   localparam logic [1:0] TurnZero = 2'b00;

   localparam logic [BandW-1:0] BandReset = BandW'(512000);

   // Sign-extend the low CoordBits bits of a field.
   function automatic logic signed [CoordBits-1:0] sext_coord(input logic [FieldW-1:0] v);
      logic [CoordBits-1:0] low;
      low = v[CoordBits-1:0];
      return signed'(low);
   endfunction

endpackage

// ----- hw/rtl/circle_box_collision_classify_unit.sv -----
// circle_box_collision_classify_unit: six-stage pipeline testing a circle against a box.
// Depends on cbcc_pkg (widths, register indexes, class codes).
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   req      | req_valid / req_ready  | req_point_x, req_point_y, req_circle_radius
//   rsp      | rsp_valid / rsp_ready  | rsp_hit_class, rsp_turn_sign
//   csr      | csr_we                 | csr_index, csr_wdata
//
// One request enters per cycle whenever req_ready is high; each result passes through
// the registered stages in order: differences, products, sums, partial products of
// the squared-distance test, row sums, final compare into the output register.
// Each stage holds while the next one is full and stalled, so bubbles are absorbed.
// Synchronous reset clears the valid bits and loads the register reset values.
module circle_box_collision_classify_unit
   import cbcc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [FieldW-1:0]   req_point_x,
   input  logic signed [FieldW-1:0]   req_point_y,
   input  logic [RadiusW-1:0]         req_circle_radius,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_hit_class,
   output logic signed [1:0]          rsp_turn_sign,
   input  logic                       csr_we,
   input  logic [CsrIdxW-1:0]         csr_index,
   input  logic [CsrW-1:0]            csr_wdata
);

   // Configuration registers
   logic [CsrW-1:0]  corner_ff [NumEdges];
   logic [CsrW-1:0]  center_ff;
   logic [CsrW-1:0]  axis_ff;
   logic [BandW-1:0] band_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NumEdges; k++) corner_ff[k] <= '0;
         center_ff <= '0;
         axis_ff   <= '0;
         band_ff   <= BandReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CORNER_A:   corner_ff[0] <= csr_wdata;
            CSR_CORNER_B:   corner_ff[1] <= csr_wdata;
            CSR_CORNER_C:   corner_ff[2] <= csr_wdata;
            CSR_CORNER_D:   corner_ff[3] <= csr_wdata;
            CSR_BOX_CENTER: center_ff    <= csr_wdata;
            CSR_AXIS:       axis_ff      <= csr_wdata;
            CSR_BAND:       band_ff      <= csr_wdata[BandW-1:0];
            default: ;
         endcase
      end
   end

   // Stage valids and per-stage advance
   localparam int NumStages = 6;
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] adv;

   always_comb begin
      adv[NumStages-1] = !vld_ff[NumStages-1] || rsp_ready;
      for (int k = NumStages - 2; k >= 0; k--) adv[k] = !vld_ff[k] || adv[k+1];
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < NumStages; k++)
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // ---------------- Stage 1: coordinate differences ----------------
   logic signed [DiffW-1:0] s1_sx_ff [NumEdges], s1_sx_in [NumEdges];
   logic signed [DiffW-1:0] s1_sy_ff [NumEdges], s1_sy_in [NumEdges];
   logic signed [DiffW-1:0] s1_tx_ff [NumEdges], s1_tx_in [NumEdges];
   logic signed [DiffW-1:0] s1_ty_ff [NumEdges], s1_ty_in [NumEdges];
   logic signed [DiffW-1:0] s1_ux_ff [NumEdges], s1_ux_in [NumEdges];
   logic signed [DiffW-1:0] s1_uy_ff [NumEdges], s1_uy_in [NumEdges];
   logic signed [DiffW-1:0] s1_qx_ff, s1_qx_in, s1_qy_ff, s1_qy_in;
   logic signed [DiffW-1:0] s1_ax_ff, s1_ax_in, s1_ay_ff, s1_ay_in;
   logic [RadW-1:0]         s1_rad_ff, s1_rad_in;

   always_comb begin
      logic signed [CoordBits-1:0] px, py, vx0, vy0, vx1, vy1;
      px = sext_coord(req_point_x);
      py = sext_coord(req_point_y);
      for (int e = 0; e < NumEdges; e++) begin
         vx0 = sext_coord(corner_ff[e][FieldW-1:0]);
         vy0 = sext_coord(corner_ff[e][CsrW-1:FieldW]);
         vx1 = sext_coord(corner_ff[(e+1)%NumEdges][FieldW-1:0]);
         vy1 = sext_coord(corner_ff[(e+1)%NumEdges][CsrW-1:FieldW]);
         s1_sx_in[e] = DiffW'(vx1) - DiffW'(vx0);
         s1_sy_in[e] = DiffW'(vy1) - DiffW'(vy0);
         s1_tx_in[e] = DiffW'(px) - DiffW'(vx0);
         s1_ty_in[e] = DiffW'(py) - DiffW'(vy0);
         s1_ux_in[e] = DiffW'(px) - DiffW'(vx1);
         s1_uy_in[e] = DiffW'(py) - DiffW'(vy1);
      end
      s1_qx_in  = DiffW'(px) - DiffW'(sext_coord(center_ff[FieldW-1:0]));
      s1_qy_in  = DiffW'(py) - DiffW'(sext_coord(center_ff[CsrW-1:FieldW]));
      s1_ax_in  = DiffW'(sext_coord(axis_ff[FieldW-1:0]));
      s1_ay_in  = DiffW'(sext_coord(axis_ff[CsrW-1:FieldW]));
      s1_rad_in = req_circle_radius[RadW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_sx_ff <= s1_sx_in; s1_sy_ff <= s1_sy_in;
         s1_tx_ff <= s1_tx_in; s1_ty_ff <= s1_ty_in;
         s1_ux_ff <= s1_ux_in; s1_uy_ff <= s1_uy_in;
         s1_qx_ff <= s1_qx_in; s1_qy_ff <= s1_qy_in;
         s1_ax_ff <= s1_ax_in; s1_ay_ff <= s1_ay_in;
         s1_rad_ff <= s1_rad_in;
      end
   end

   // ---------------- Stage 2: products ----------------
   // per edge: 0 sx*ty, 1 sy*tx, 2 sx*sx, 3 sy*sy, 4 sx*tx, 5 sy*ty,
   //           6 sx*ux, 7 sy*uy, 8 tx*tx, 9 ty*ty, 10 ux*ux, 11 uy*uy
   localparam int NumProd = 12;
   logic signed [ProdW-1:0] s2_p_ff [NumEdges][NumProd], s2_p_in [NumEdges][NumProd];
   logic signed [ProdW-1:0] s2_axq_ff [4], s2_axq_in [4];
   logic [R2W-1:0]          s2_r2_ff, s2_r2_in;

   always_comb begin
      for (int e = 0; e < NumEdges; e++) begin
         s2_p_in[e][0]  = ProdW'(s1_sx_ff[e]) * ProdW'(s1_ty_ff[e]);
         s2_p_in[e][1]  = ProdW'(s1_sy_ff[e]) * ProdW'(s1_tx_ff[e]);
         s2_p_in[e][2]  = ProdW'(s1_sx_ff[e]) * ProdW'(s1_sx_ff[e]);
         s2_p_in[e][3]  = ProdW'(s1_sy_ff[e]) * ProdW'(s1_sy_ff[e]);
         s2_p_in[e][4]  = ProdW'(s1_sx_ff[e]) * ProdW'(s1_tx_ff[e]);
         s2_p_in[e][5]  = ProdW'(s1_sy_ff[e]) * ProdW'(s1_ty_ff[e]);
         s2_p_in[e][6]  = ProdW'(s1_sx_ff[e]) * ProdW'(s1_ux_ff[e]);
         s2_p_in[e][7]  = ProdW'(s1_sy_ff[e]) * ProdW'(s1_uy_ff[e]);
         s2_p_in[e][8]  = ProdW'(s1_tx_ff[e]) * ProdW'(s1_tx_ff[e]);
         s2_p_in[e][9]  = ProdW'(s1_ty_ff[e]) * ProdW'(s1_ty_ff[e]);
         s2_p_in[e][10] = ProdW'(s1_ux_ff[e]) * ProdW'(s1_ux_ff[e]);
         s2_p_in[e][11] = ProdW'(s1_uy_ff[e]) * ProdW'(s1_uy_ff[e]);
      end
      // axis dot terms 0,1 and cross terms 2,3
      s2_axq_in[0] = ProdW'(s1_ax_ff) * ProdW'(s1_qx_ff);
      s2_axq_in[1] = ProdW'(s1_ay_ff) * ProdW'(s1_qy_ff);
      s2_axq_in[2] = ProdW'(s1_ax_ff) * ProdW'(s1_qy_ff);
      s2_axq_in[3] = ProdW'(s1_ay_ff) * ProdW'(s1_qx_ff);
      s2_r2_in = R2W'(s1_rad_ff) * R2W'(s1_rad_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_p_ff   <= s2_p_in;
         s2_axq_ff <= s2_axq_in;
         s2_r2_ff  <= s2_r2_in;
      end
   end

   // ---------------- Stage 3: sums, magnitudes and signs ----------------
   logic [MagW-1:0] s3_cmag_ff [NumEdges], s3_cmag_in [NumEdges];
   logic [MagW-1:0] s3_l2_ff [NumEdges], s3_l2_in [NumEdges];
   logic [MagW-1:0] s3_lt_ff [NumEdges], s3_lt_in [NumEdges];
   logic [MagW-1:0] s3_lu_ff [NumEdges], s3_lu_in [NumEdges];
   logic [NumEdges-1:0] s3_cpos_ff, s3_cpos_in, s3_dsame_ff, s3_dsame_in;
   logic [MagW-1:0] s3_dmag_ff, s3_dmag_in;
   logic            s3_dneg_ff, s3_dneg_in, s3_dnz_ff, s3_dnz_in;
   logic            s3_crneg_ff, s3_crneg_in, s3_crnz_ff, s3_crnz_in;
   logic [R2W-1:0]  s3_r2_ff;

   always_comb begin
      logic signed [SumW-1:0] c, d1, d2, ad, cr, sq;
      for (int e = 0; e < NumEdges; e++) begin
         c  = SumW'(s2_p_ff[e][0]) - SumW'(s2_p_ff[e][1]);
         d1 = SumW'(s2_p_ff[e][4]) + SumW'(s2_p_ff[e][5]);
         d2 = SumW'(s2_p_ff[e][6]) + SumW'(s2_p_ff[e][7]);
         s3_cpos_in[e]  = !c[SumW-1] && (c != '0);
         s3_cmag_in[e]  = c[SumW-1] ? MagW'(-c) : MagW'(c);
         s3_dsame_in[e] = (d1 != '0) && (d2 != '0) && (d1[SumW-1] == d2[SumW-1]);
         sq = SumW'(s2_p_ff[e][2]) + SumW'(s2_p_ff[e][3]);
         s3_l2_in[e] = MagW'(sq);
         sq = SumW'(s2_p_ff[e][8]) + SumW'(s2_p_ff[e][9]);
         s3_lt_in[e] = MagW'(sq);
         sq = SumW'(s2_p_ff[e][10]) + SumW'(s2_p_ff[e][11]);
         s3_lu_in[e] = MagW'(sq);
      end
      ad = SumW'(s2_axq_ff[0]) + SumW'(s2_axq_ff[1]);
      cr = SumW'(s2_axq_ff[2]) - SumW'(s2_axq_ff[3]);
      s3_dneg_in  = ad[SumW-1];
      s3_dnz_in   = (ad != '0);
      s3_dmag_in  = ad[SumW-1] ? MagW'(-ad) : MagW'(ad);
      s3_crneg_in = cr[SumW-1];
      s3_crnz_in  = (cr != '0);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_cmag_ff <= s3_cmag_in; s3_l2_ff <= s3_l2_in;
         s3_lt_ff <= s3_lt_in;     s3_lu_ff <= s3_lu_in;
         s3_cpos_ff <= s3_cpos_in; s3_dsame_ff <= s3_dsame_in;
         s3_dmag_ff <= s3_dmag_in; s3_dneg_ff <= s3_dneg_in; s3_dnz_ff <= s3_dnz_in;
         s3_crneg_ff <= s3_crneg_in; s3_crnz_ff <= s3_crnz_in;
         s3_r2_ff <= s2_r2_ff;
      end
   end

   // ---------------- Stage 4: partial products, endpoint and band tests ----------------
   logic [PpW-1:0] s4_ppc_ff [NumEdges][NumCh][NumCh], s4_ppc_in [NumEdges][NumCh][NumCh];
   logic [PpW-1:0] s4_ppr_ff [NumEdges][NumCh][NumCh], s4_ppr_in [NumEdges][NumCh][NumCh];
   logic [NumEdges-1:0] s4_l2nz_ff, s4_l2nz_in, s4_near_ff, s4_near_in;
   logic s4_inside_ff, s4_inside_in, s4_center_ff, s4_center_in, s4_tneg_ff, s4_tneg_in;

   always_comb begin
      logic [PadW-1:0] ca, la, ra;
      logic [MagW-1:0] r2m;
      r2m = MagW'(s3_r2_ff);
      ra  = PadW'(s3_r2_ff);
      for (int e = 0; e < NumEdges; e++) begin
         ca = PadW'(s3_cmag_ff[e]);
         la = PadW'(s3_l2_ff[e]);
         for (int i = 0; i < NumCh; i++)
            for (int j = 0; j < NumCh; j++) begin
               s4_ppc_in[e][i][j] = PpW'(ca[i*ChunkW +: ChunkW]) * PpW'(ca[j*ChunkW +: ChunkW]);
               s4_ppr_in[e][i][j] = PpW'(ra[i*ChunkW +: ChunkW]) * PpW'(la[j*ChunkW +: ChunkW]);
            end
         s4_l2nz_in[e] = (s3_l2_ff[e] != '0);
         s4_near_in[e] = !s3_dsame_ff[e] || (r2m >= s3_lt_ff[e]) || (r2m >= s3_lu_ff[e]);
      end
      s4_inside_in = (s3_cpos_ff == '0);
      s4_center_in = s3_dmag_ff < MagW'({band_ff, FracBits'(0)});
      s4_tneg_in   = s3_crnz_ff && s3_dnz_ff && (s3_crneg_ff != s3_dneg_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_ppc_ff <= s4_ppc_in; s4_ppr_ff <= s4_ppr_in;
         s4_l2nz_ff <= s4_l2nz_in; s4_near_ff <= s4_near_in;
         s4_inside_ff <= s4_inside_in; s4_center_ff <= s4_center_in;
         s4_tneg_ff <= s4_tneg_in;
      end
   end

   // ---------------- Stage 5: row sums ----------------
   logic [RowW-1:0] s5_rowc_ff [NumEdges][NumCh], s5_rowc_in [NumEdges][NumCh];
   logic [RowW-1:0] s5_rowr_ff [NumEdges][NumCh], s5_rowr_in [NumEdges][NumCh];
   logic [NumEdges-1:0] s5_l2nz_ff, s5_near_ff;
   logic s5_inside_ff, s5_center_ff, s5_tneg_ff;

   always_comb begin
      for (int e = 0; e < NumEdges; e++)
         for (int i = 0; i < NumCh; i++) begin
            s5_rowc_in[e][i] = '0;
            s5_rowr_in[e][i] = '0;
            for (int j = 0; j < NumCh; j++) begin
               s5_rowc_in[e][i] += RowW'(s4_ppc_ff[e][i][j]) << (j * ChunkW);
               s5_rowr_in[e][i] += RowW'(s4_ppr_ff[e][i][j]) << (j * ChunkW);
            end
         end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_rowc_ff <= s5_rowc_in; s5_rowr_ff <= s5_rowr_in;
         s5_l2nz_ff <= s4_l2nz_ff; s5_near_ff <= s4_near_ff;
         s5_inside_ff <= s4_inside_ff; s5_center_ff <= s4_center_ff;
         s5_tneg_ff <= s4_tneg_ff;
      end
   end

   // ---------------- Stage 6: final compare, classify, output register ----------------
   logic [1:0]        s6_class_ff, s6_class_in;
   logic signed [1:0] s6_turn_ff, s6_turn_in;

   always_comb begin
      logic [FullW-1:0] c2, rl;
      logic             hit;
      hit = s5_inside_ff;
      for (int e = 0; e < NumEdges; e++) begin
         c2 = '0;
         rl = '0;
         for (int i = 0; i < NumCh; i++) begin
            c2 += FullW'(s5_rowc_ff[e][i]) << (i * ChunkW);
            rl += FullW'(s5_rowr_ff[e][i]) << (i * ChunkW);
         end
         if (s5_l2nz_ff[e] && (c2 < rl) && s5_near_ff[e]) hit = 1'b1;
      end
      s6_class_in = HIT_NONE;
      s6_turn_in  = TurnZero;
      if (hit) begin
         if (s5_center_ff) begin
            s6_class_in = HIT_CENTER;
         end else begin
            s6_class_in = HIT_SIDE;
            s6_turn_in  = s5_tneg_ff ? TurnNeg : TurnPos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_class_ff <= s6_class_in;
         s6_turn_ff  <= s6_turn_in;
      end
   end

   assign rsp_valid     = vld_ff[NumStages-1];
   assign rsp_hit_class = s6_class_ff;
   assign rsp_turn_sign = s6_turn_ff;

endmodule
